[rtl/sct_pkg.sv]
// ----------------------------------------------------------------------------
// Segment crossing test package
// Shared constants for the segment crossing test pipeline.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int PREC_W         = 31;
    localparam int THR_W          = 63;
    localparam int CFG_DATA_W     = 63;
    localparam int CFG_IDX_W      = 2;

    localparam logic [PREC_W-1:0] PREC_RESET = PREC_W'(66);
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(1);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(1);

    // Multiplier partial product chunk width and pipeline depth.
    localparam int MUL_CHUNK = 32;
    localparam int MUL_LAT   = 4;

endpackage

[rtl/segment_crossing_test_unit.sv]
// Throughput: one segment pair per cycle while the output is not stalled; the
// square root pipeline, one bit per stage, sets the depth.
// A stall on the output holds the whole pipeline; nothing is lost or repeated.
// Synchronous active-low reset empties the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
// Segment crossing test unit
// Robust fixed-point test of whether two 2D segments cross inside both.
// ----------------------------------------------------------------------------
module segment_crossing_test_unit
    import sct_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_p_start_x,
    input  logic signed [COORD_BITS-1:0] i_p_start_y,
    input  logic signed [COORD_BITS-1:0] i_p_end_x,
    input  logic signed [COORD_BITS-1:0] i_p_end_y,
    input  logic signed [COORD_BITS-1:0] i_q_start_x,
    input  logic signed [COORD_BITS-1:0] i_q_start_y,
    input  logic signed [COORD_BITS-1:0] i_q_end_x,
    input  logic signed [COORD_BITS-1:0] i_q_end_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_crosses
);

    localparam int CB   = COORD_BITS;
    localparam int DW   = CB + 1;
    localparam int CW   = 2 * DW + 1;
    localparam int LW   = CB + 1;
    localparam int MA   = CW + 1;
    localparam int MB   = (LW + 1 > PREC_W + 2) ? LW + 1 : PREC_W + 2;
    localparam int MW   = MA + MB;
    localparam int XW   = MW + 1;
    localparam int CMPW = (CW > THR_W + 1) ? CW : THR_W + 1;
    localparam int LAT  = LW + 2 * MUL_LAT + 4;
    localparam int NM1  = 12;
    localparam int NM2  = 10;
    localparam int DLY  = LW - 1;

    typedef struct packed {
        logic                 flip;
        logic                 par;
        logic signed [MA-1:0] dd;
        logic signed [MA-1:0] tp;
        logic signed [MA-1:0] tq;
        logic signed [MA-1:0] dmt;
        logic signed [MA-1:0] dmq;
        logic signed [MA-1:0] cdr;
        logic signed [MA-1:0] cds;
        logic signed [MA-1:0] sr;
        logic signed [MA-1:0] dot;
    } t_geo;

    logic                 w_en;
    logic                 w_in_acc;
    logic [LAT-1:0]       r_vld;
    logic [PREC_W-1:0]    r_prec;
    logic [THR_W-1:0]     r_thr;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prec <= PREC_RESET;
            r_thr  <= THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PRECISION: r_prec <= i_cfg_data[PREC_W-1:0];
                CFG_THRESHOLD: r_thr  <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // One enable moves every stage; the output beat holds while stalled.
    assign o_stall  = r_vld[LAT-1] && i_stall;
    assign w_en     = !o_stall;
    assign w_in_acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], w_in_acc};
        end
    end

    // Stage 1: direction and offset vectors.
    logic signed [DW-1:0] r_rx, r_ry, r_sx, r_sy, r_dx, r_dy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rx <= DW'(i_p_end_x) - DW'(i_p_start_x);
            r_ry <= DW'(i_p_end_y) - DW'(i_p_start_y);
            r_sx <= DW'(i_q_end_x) - DW'(i_q_start_x);
            r_sy <= DW'(i_q_end_y) - DW'(i_q_start_y);
            r_dx <= DW'(i_q_start_x) - DW'(i_p_start_x);
            r_dy <= DW'(i_q_start_y) - DW'(i_p_start_y);
        end
    end

    // First multiplier bank: the pairwise vector products that stage A combines.
    logic signed [DW-1:0]   w_a1 [NM1];
    logic signed [DW-1:0]   w_b1 [NM1];
    logic signed [2*DW-1:0] w_p1 [NM1];

    assign w_a1[0]  = r_rx;  assign w_b1[0]  = r_sy;
    assign w_a1[1]  = r_ry;  assign w_b1[1]  = r_sx;
    assign w_a1[2]  = r_dx;  assign w_b1[2]  = r_ry;
    assign w_a1[3]  = r_dy;  assign w_b1[3]  = r_rx;
    assign w_a1[4]  = r_dx;  assign w_b1[4]  = r_sy;
    assign w_a1[5]  = r_dy;  assign w_b1[5]  = r_sx;
    assign w_a1[6]  = r_rx;  assign w_b1[6]  = r_rx;
    assign w_a1[7]  = r_ry;  assign w_b1[7]  = r_ry;
    assign w_a1[8]  = r_sx;  assign w_b1[8]  = r_sx;
    assign w_a1[9]  = r_sy;  assign w_b1[9]  = r_sy;
    assign w_a1[10] = r_rx;  assign w_b1[10] = r_sx;
    assign w_a1[11] = r_ry;  assign w_b1[11] = r_sy;

    for (genvar gm = 0; gm < NM1; gm++) begin : g_mul1
        sct_mul #(
            .WA (DW),
            .WB (DW)
        ) u_mul (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_a1[gm]),
            .i_b   (w_b1[gm]),
            .o_p   (w_p1[gm])
        );
    end

    // Stage A: cross products, squared lengths and the dot product.
    logic signed [CW-1:0] r_rxs, r_cdr, r_cds, r_sr, r_ss, r_dot;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rxs <= CW'(w_p1[0])  - CW'(w_p1[1]);
            r_cdr <= CW'(w_p1[2])  - CW'(w_p1[3]);
            r_cds <= CW'(w_p1[4])  - CW'(w_p1[5]);
            r_sr  <= CW'(w_p1[6])  + CW'(w_p1[7]);
            r_ss  <= CW'(w_p1[8])  + CW'(w_p1[9]);
            r_dot <= CW'(w_p1[10]) + CW'(w_p1[11]);
        end
    end

    logic [LW-1:0] w_lr, w_ls;

    sct_isqrt #(.LW(LW)) u_sqrt_r (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r_sr[2*LW-1:0]),
        .o_root (w_lr)
    );

    sct_isqrt #(.LW(LW)) u_sqrt_s (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r_ss[2*LW-1:0]),
        .o_root (w_ls)
    );

    // Stage B: orient by the sign of the direction cross product; flag near-parallel pairs.
    logic                 r_b_flip, r_b_par;
    logic signed [CW-1:0] r_b_dd, r_b_tp, r_b_tq, r_b_cdr, r_b_cds, r_b_sr, r_b_dot;
    logic signed [CW-1:0] w_dd;
    logic signed [CMPW-1:0] w_dd_x, w_thr_x;

    assign w_dd    = r_rxs[CW-1] ? -r_rxs : r_rxs;
    assign w_dd_x  = CMPW'(w_dd);
    assign w_thr_x = CMPW'($signed({1'b0, r_thr}));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_flip <= r_rxs[CW-1];
            r_b_par  <= (w_dd_x < w_thr_x) || (w_dd == '0);
            r_b_dd   <= w_dd;
            r_b_tp   <= r_rxs[CW-1] ? -r_cds : r_cds;
            r_b_tq   <= r_rxs[CW-1] ? -r_cdr : r_cdr;
            r_b_cdr  <= r_cdr;
            r_b_cds  <= r_cds;
            r_b_sr   <= r_sr;
            r_b_dot  <= r_dot;
        end
    end

    // Stage C feeds a delay line that waits for the square roots.
    t_geo w_geo_c;
    t_geo r_dly [DLY];
    t_geo w_geo;

    always_comb begin
        w_geo_c.flip = r_b_flip;
        w_geo_c.par  = r_b_par;
        w_geo_c.dd   = MA'(r_b_dd);
        w_geo_c.tp   = MA'(r_b_tp);
        w_geo_c.tq   = MA'(r_b_tq);
        w_geo_c.dmt  = MA'(r_b_dd) - MA'(r_b_tp);
        w_geo_c.dmq  = MA'(r_b_dd) - MA'(r_b_tq);
        w_geo_c.cdr  = MA'(r_b_cdr);
        w_geo_c.cds  = MA'(r_b_cds);
        w_geo_c.sr   = MA'(r_b_sr);
        w_geo_c.dot  = MA'(r_b_dot);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly[0] <= w_geo_c;
            for (int k = 1; k < DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign w_geo = r_dly[DLY-1];

    // Second multiplier bank: scale by lengths and by the tolerance.
    logic signed [MB-1:0] w_lr_m, w_ls_m, w_prec_m, w_prec2_m;
    logic signed [MA-1:0] w_a2 [NM2];
    logic signed [MB-1:0] w_b2 [NM2];
    logic signed [MW-1:0] w_p2 [NM2];

    assign w_lr_m    = $signed(MB'(w_lr));
    assign w_ls_m    = $signed(MB'(w_ls));
    assign w_prec_m  = $signed(MB'(r_prec));
    assign w_prec2_m = $signed(MB'({r_prec, 1'b0}));

    assign w_a2[0] = w_geo.tp;   assign w_b2[0] = w_lr_m;
    assign w_a2[1] = w_geo.dmt;  assign w_b2[1] = w_lr_m;
    assign w_a2[2] = w_geo.tq;   assign w_b2[2] = w_ls_m;
    assign w_a2[3] = w_geo.dmq;  assign w_b2[3] = w_ls_m;
    assign w_a2[4] = w_geo.cdr;  assign w_b2[4] = w_lr_m;
    assign w_a2[5] = w_geo.cds;  assign w_b2[5] = w_lr_m;
    assign w_a2[6] = w_geo.dd;   assign w_b2[6] = w_lr_m;
    assign w_a2[7] = w_geo.sr;   assign w_b2[7] = w_prec_m;
    assign w_a2[8] = w_geo.dot;  assign w_b2[8] = w_prec_m;
    assign w_a2[9] = w_geo.dd;   assign w_b2[9] = w_prec2_m;

    for (genvar gn = 0; gn < NM2; gn++) begin : g_mul2
        sct_mul #(
            .WA (MA),
            .WB (MB)
        ) u_mul (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_a2[gn]),
            .i_b   (w_b2[gn]),
            .o_p   (w_p2[gn])
        );
    end

    logic [MUL_LAT-1:0] r_m_flip, r_m_par;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_flip <= {r_m_flip[MUL_LAT-2:0], w_geo.flip};
            r_m_par  <= {r_m_par[MUL_LAT-2:0], w_geo.par};
        end
    end

    // Stage D: end trimming checks and the shifted crossing values.
    logic                 r_d_flip, r_d_par, r_d_ok;
    logic signed [XW-1:0] r_x [4];
    logic signed [XW-1:0] r_dl, r_ndl;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_flip <= r_m_flip[MUL_LAT-1];
            r_d_par  <= r_m_par[MUL_LAT-1];
            r_d_ok   <= (w_p2[9] <= w_p2[0]) && (w_p2[9] <= w_p2[1]) &&
                        (w_p2[9] <= w_p2[2]) && (w_p2[9] <= w_p2[3]);
            r_x[0]   <= XW'(w_p2[4]) - XW'(w_p2[7]);
            r_x[1]   <= XW'(w_p2[4]) + XW'(w_p2[7]);
            r_x[2]   <= XW'(w_p2[5]) - XW'(w_p2[8]);
            r_x[3]   <= XW'(w_p2[5]) + XW'(w_p2[8]);
            r_dl     <= XW'(w_p2[6]);
            r_ndl    <= -XW'(w_p2[6]);
        end
    end

    // Stage E: each value, oriented, must lie within [0, D*Lr].
    // The sign tests look at the top bit so they stay signed.
    logic [3:0] w_in;
    logic       r_out;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_d_flip) begin
                w_in[k] = (r_x[k][XW-1] || (r_x[k] == '0)) && (r_x[k] >= r_ndl);
            end else begin
                w_in[k] = !r_x[k][XW-1] && (r_x[k] <= r_dl);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= !r_d_par && r_d_ok && (&w_in);
        end
    end

    assign o_valid   = r_vld[LAT-1];
    assign o_crosses = r_out;

endmodule

[rtl/sct_mul.sv]
// ----------------------------------------------------------------------------
// Pipelined signed multiplier
// Sign-magnitude multiplier built from 32x32 partial products, four stages.
// ----------------------------------------------------------------------------
module sct_mul
    import sct_pkg::*;
#(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [WA-1:0]        i_a,
    input  logic signed [WB-1:0]        i_b,
    output logic signed [WA+WB-1:0]     o_p
);

    localparam int CH = MUL_CHUNK;
    localparam int NA = (WA + CH - 1) / CH;
    localparam int NB = (WB + CH - 1) / CH;
    localparam int NP = NA * NB;
    localparam int SW = (NA + NB) * CH;
    localparam int PW = WA + WB;

    logic [WA-1:0]      w_aa;
    logic [WB-1:0]      w_ab;
    logic [NA*CH-1:0]   r_ma;
    logic [NB*CH-1:0]   r_mb;
    logic               r_sg1, r_sg2, r_sg3;
    logic [2*CH-1:0]    r_pp [NP];
    logic [SW-1:0]      n_sum;
    logic [SW-1:0]      r_sum;
    logic signed [PW-1:0] r_p;

    assign w_aa = i_a[WA-1] ? (~i_a + 1'b1) : i_a;
    assign w_ab = i_b[WB-1] ? (~i_b + 1'b1) : i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma  <= (NA*CH)'(w_aa);
            r_mb  <= (NB*CH)'(w_ab);
            r_sg1 <= i_a[WA-1] ^ i_b[WB-1];
            r_sg2 <= r_sg1;
            r_sg3 <= r_sg2;
        end
    end

    for (genvar gi = 0; gi < NA; gi++) begin : g_row
        for (genvar gj = 0; gj < NB; gj++) begin : g_col
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pp[gi*NB+gj] <= r_ma[gi*CH +: CH] * r_mb[gj*CH +: CH];
                end
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_sum = n_sum + (SW'(r_pp[i*NB+j]) << ((i + j) * CH));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
            r_p   <= r_sg3 ? -$signed(r_sum[PW-1:0]) : $signed(r_sum[PW-1:0]);
        end
    end

    assign o_p = r_p;

endmodule

[rtl/sct_isqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module sct_isqrt
    import sct_pkg::*;
#(
    parameter int LW = 33
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [2*LW-1:0]     i_val,
    output logic [LW-1:0]       o_root
);

    localparam int RW = LW + 3;

    logic [RW-1:0]     r_rem  [LW];
    logic [LW-1:0]     r_root [LW];
    logic [2*LW-1:0]   r_v    [LW];

    for (genvar gk = 0; gk < LW; gk++) begin : g_stage
        logic [RW-1:0]   w_rem_in;
        logic [LW-1:0]   w_root_in;
        logic [2*LW-1:0] w_v_in;
        logic [RW-1:0]   w_cur;
        logic [RW-1:0]   w_try;

        if (gk == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_v_in    = i_val;
        end else begin : g_next
            assign w_rem_in  = r_rem[gk-1];
            assign w_root_in = r_root[gk-1];
            assign w_v_in    = r_v[gk-1];
        end

        // Bring down the next pair of radicand bits and try a one bit.
        assign w_cur = {w_rem_in[RW-3:0], w_v_in[2*LW-1 -: 2]};
        assign w_try = RW'({w_root_in, 2'b01});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[gk] <= {w_v_in[2*LW-3:0], 2'b00};
                if (w_cur >= w_try) begin
                    r_rem[gk]  <= w_cur - w_try;
                    r_root[gk] <= {w_root_in[LW-2:0], 1'b1};
                end else begin
                    r_rem[gk]  <= w_cur;
                    r_root[gk] <= {w_root_in[LW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[LW-1];

endmodule

[rtl/sct_checker.sv]
// ----------------------------------------------------------------------------
// Segment crossing test checker
// Port-level assertions on the handshake and reset of the top level.
// ----------------------------------------------------------------------------
module sct_checker
    import sct_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_crosses
);

    // The block only pushes back when it holds a beat that is not taken.
    a_stall_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("stall raised without a blocked output beat");

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // A blocked output beat stays.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("output beat dropped while stalled");

    // A blocked output beat keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_crosses))
        else $error("output beat changed while stalled");

    // The input valid is always driven to a known level out of reset.
    a_valid_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(i_valid))
        else $error("input valid unknown");

endmodule

bind segment_crossing_test_unit sct_checker u_sct_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_crosses (o_crosses)
);
